>>> src/epoch_seconds_to_calendar_macros.svh
// Assertion shorthands for the epoch-to-calendar block.
// Each one samples on clk and is off while arst_n is low.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Same-cycle implication.
`define ESC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ESC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/esc_pkg.sv
package esc_pkg;

	// Per-stage load enables of the six-stage pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} esc_load_t;

	// seconds / 86400 == (seconds >> 7) / 675, done as a multiply by 2^34/675.
	localparam int             DAY_SHIFT  = 7;
	localparam logic [24:0]    DAY_RECIP  = 25'd25451659;
	localparam int             DAY_QSHIFT = 34;
	localparam logic [9:0]     DAY_ODD    = 10'd675;

	// Day count rebased to 1968-01-01, first day of a leap year.
	localparam logic [14:0]    DAY_REBASE = 15'd731;
	localparam logic [10:0]    YEAR_BASE  = 11'd1968;
	localparam logic [10:0]    QUAD_DAYS  = 11'd1461;
	localparam logic [15:0]    QUAD_RECIP = 16'd45934;
	localparam int             QUAD_SHIFT = 26;

	// Days at which years two, three and four of a four-year cycle start.
	localparam logic [10:0]    Y1_START   = 11'd366;
	localparam logic [10:0]    Y2_START   = 11'd731;
	localparam logic [10:0]    Y3_START   = 11'd1096;

	// 1970-01-01 was a Thursday.
	localparam logic [14:0]    EPOCH_WDAY = 15'd4;
	localparam logic [3:0]     WEEK_DAYS  = 4'd7;

	// tod / 3600 == (tod >> 4) / 225; rem / 60 == (rem >> 2) / 15.
	localparam logic [13:0]    HOUR_RECIP = 14'd9321;
	localparam int             HOUR_SHIFT = 21;
	localparam logic [16:0]    SECS_HOUR  = 17'd3600;
	localparam logic [10:0]    MIN_RECIP  = 11'd1093;
	localparam int             MIN_SHIFT  = 14;
	localparam logic [11:0]    SECS_MIN   = 12'd60;

	localparam logic [3:0]     LAST_MONTH = 4'd11;

	// First day-of-year (0-based) of a month.
	function automatic logic [8:0] month_first(input logic [3:0] mon, input logic leap);
		logic [8:0] base;
		unique case (mon)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + {8'd0, (leap && (mon >= 4'd2))};
	endfunction

endpackage

>>> src/esc_split.sv
module esc_split (
	input  logic                clk,
	input  esc_pkg::esc_load_t  load,
	input  logic [30:0]         epoch_seconds,
	output logic [14:0]         days_s2,
	output logic [16:0]         tod_s2
);
	import esc_pkg::*;

	logic [23:0] blk;
	logic [48:0] prod;
	logic [48:0] prod_s1;
	logic [23:0] blk_s1;
	logic [6:0]  lo_s1;
	logic [14:0] days;
	logic [23:0] blk_rem;

	assign blk  = epoch_seconds[30:DAY_SHIFT];
	assign prod = {25'd0, blk} * {24'd0, DAY_RECIP};

	always_ff @(posedge clk) begin
		if (load.s1) begin
			prod_s1 <= prod;
			blk_s1  <= blk;
			lo_s1   <= epoch_seconds[DAY_SHIFT-1:0];
		end
	end

	// Exact quotient for any 24-bit dividend; recover the remainder by back-multiply.
	assign days    = prod_s1[DAY_QSHIFT +: 15];
	assign blk_rem = blk_s1 - 24'({9'd0, days} * {14'd0, DAY_ODD});

	always_ff @(posedge clk) begin
		if (load.s2) begin
			days_s2 <= days;
			tod_s2  <= {blk_rem[9:0], lo_s1};
		end
	end

endmodule

>>> src/esc_date.sv
module esc_date (
	input  logic                clk,
	input  esc_pkg::esc_load_t  load,
	input  logic [14:0]         days_s2,
	output logic [10:0]         year_s6,
	output logic [3:0]          month_s6,
	output logic [4:0]          mday_s6,
	output logic [2:0]          wday_s6
);
	import esc_pkg::*;

	logic [14:0] rday;
	logic [30:0] qprod;
	logic [14:0] wsum_in;
	logic [5:0]  wsum;
	logic [3:0]  wfold;
	logic [2:0]  wday;
	logic [30:0] qprod_s3;
	logic [14:0] rday_s3;
	logic [2:0]  wday_s3;
	logic [4:0]  quad;
	logic [14:0] rquad;
	logic [4:0]  quad_s4;
	logic [10:0] rquad_s4;
	logic [2:0]  wday_s4;
	logic [1:0]  yic;
	logic [10:0] ystart;
	logic [10:0] doy_w;
	logic [10:0] year_s5;
	logic [8:0]  doy_s5;
	logic        leap_s5;
	logic [2:0]  wday_s5;
	logic [3:0]  mon;
	logic [8:0]  mday_w;

	// Stage 3: rebase, start the divide by 1461, fold the weekday mod 7.
	assign rday    = days_s2 + DAY_REBASE;
	assign qprod   = {16'd0, rday} * {15'd0, QUAD_RECIP};
	assign wsum_in = days_s2 + EPOCH_WDAY;
	assign wsum    = 6'(wsum_in[2:0]) + 6'(wsum_in[5:3]) + 6'(wsum_in[8:6])
	               + 6'(wsum_in[11:9]) + 6'(wsum_in[14:12]);
	assign wfold   = 4'(wsum[2:0]) + 4'(wsum[5:3]);
	assign wday    = (wfold >= WEEK_DAYS) ? 3'(wfold - WEEK_DAYS) : wfold[2:0];

	always_ff @(posedge clk) begin
		if (load.s3) begin
			qprod_s3 <= qprod;
			rday_s3  <= rday;
			wday_s3  <= wday;
		end
	end

	// Stage 4: four-year cycle number and day within the cycle.
	assign quad  = qprod_s3[QUAD_SHIFT +: 5];
	assign rquad = rday_s3 - 15'({10'd0, quad} * {4'd0, QUAD_DAYS});

	always_ff @(posedge clk) begin
		if (load.s4) begin
			quad_s4  <= quad;
			rquad_s4 <= rquad[10:0];
			wday_s4  <= wday_s3;
		end
	end

	// Stage 5: year within the cycle; the first one is the leap year.
	always_comb begin
		priority if (rquad_s4 < Y1_START) begin
			yic    = 2'd0;
			ystart = 11'd0;
		end else if (rquad_s4 < Y2_START) begin
			yic    = 2'd1;
			ystart = Y1_START;
		end else if (rquad_s4 < Y3_START) begin
			yic    = 2'd2;
			ystart = Y2_START;
		end else begin
			yic    = 2'd3;
			ystart = Y3_START;
		end
	end

	assign doy_w = rquad_s4 - ystart;

	always_ff @(posedge clk) begin
		if (load.s5) begin
			year_s5 <= YEAR_BASE + 11'({quad_s4, yic});
			doy_s5  <= doy_w[8:0];
			leap_s5 <= (yic == 2'd0);
			wday_s5 <= wday_s4;
		end
	end

	// Stage 6: month by compare against each month start, then day of month.
	always_comb begin
		mon = '0;
		for (int m = 1; m <= 11; m++) begin
			if (doy_s5 >= month_first(4'(m), leap_s5))
				mon = 4'(m);
		end
		mday_w = doy_s5 - month_first(mon, leap_s5) + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (load.s6) begin
			year_s6  <= year_s5;
			month_s6 <= mon;
			mday_s6  <= mday_w[4:0];
			wday_s6  <= wday_s5;
		end
	end

endmodule

>>> src/esc_clock.sv
module esc_clock (
	input  logic                clk,
	input  esc_pkg::esc_load_t  load,
	input  logic [16:0]         tod_s2,
	output logic [4:0]          hour_s6,
	output logic [5:0]          min_s6,
	output logic [5:0]          sec_s6
);
	import esc_pkg::*;

	logic [26:0] hprod;
	logic [26:0] hprod_s3;
	logic [16:0] tod_s3;
	logic [4:0]  hour;
	logic [16:0] hrem;
	logic [4:0]  hour_s4;
	logic [11:0] rem_s4;
	logic [20:0] mprod;
	logic [20:0] mprod_s5;
	logic [11:0] rem_s5;
	logic [4:0]  hour_s5;
	logic [5:0]  mins;
	logic [11:0] srem;

	// Stage 3: start tod / 3600.
	assign hprod = {14'd0, tod_s2[16:4]} * {13'd0, HOUR_RECIP};

	always_ff @(posedge clk) begin
		if (load.s3) begin
			hprod_s3 <= hprod;
			tod_s3   <= tod_s2;
		end
	end

	// Stage 4: hour and seconds within the hour.
	assign hour = hprod_s3[HOUR_SHIFT +: 5];
	assign hrem = tod_s3 - 17'({12'd0, hour} * SECS_HOUR);

	always_ff @(posedge clk) begin
		if (load.s4) begin
			hour_s4 <= hour;
			rem_s4  <= hrem[11:0];
		end
	end

	// Stage 5: start rem / 60.
	assign mprod = {11'd0, rem_s4[11:2]} * {10'd0, MIN_RECIP};

	always_ff @(posedge clk) begin
		if (load.s5) begin
			mprod_s5 <= mprod;
			rem_s5   <= rem_s4;
			hour_s5  <= hour_s4;
		end
	end

	// Stage 6: minute and second.
	assign mins = mprod_s5[MIN_SHIFT +: 6];
	assign srem = rem_s5 - 12'({6'd0, mins} * SECS_MIN);

	always_ff @(posedge clk) begin
		if (load.s6) begin
			hour_s6 <= hour_s5;
			min_s6  <= mins;
			sec_s6  <= srem[5:0];
		end
	end

endmodule

>>> src/epoch_seconds_to_calendar.sv
// Converts a 31-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// Gregorian year, month (0 = January), day of month (from 1), weekday
// (0 = Sunday) and hour, minute and second. It accepts one word every clock
// while epoch_stall is low. The result word leaves the output on an edge at
// which the output side does not stall. Six register stages lie between
// input and output: the day split and its remainder; then, for the date,
// the divide by four-year cycles, its remainder, the year pick and the month
// search; and, for the time, the hour and minute divides by reciprocal
// multiply, each with its remainder. Stalls back up stage by stage, so empty
// stages keep filling while the output waits, and nothing is dropped or
// repeated. Every input value is a valid time: no word is ever rejected.
`include "epoch_seconds_to_calendar_macros.svh"

module epoch_seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        epoch_valid,
	output logic        epoch_stall,
	input  logic [30:0] epoch_seconds,
	output logic        cal_valid,
	input  logic        cal_stall,
	output logic [10:0] year_number,
	output logic [3:0]  month_index,
	output logic [4:0]  day_of_month,
	output logic [2:0]  weekday,
	output logic [4:0]  hour_of_day,
	output logic [5:0]  minute_of_hour,
	output logic [5:0]  second_of_minute
);
	import esc_pkg::*;

	// Valid bit of each pipeline stage, index 1 is the first stage.
	logic [6:1]  stage_vld_q;
	esc_load_t   load;
	logic [14:0] days_s2;
	logic [16:0] tod_s2;

	// A stage loads when it is empty or its word moves on in the same cycle.
	always_comb begin
		load.s6 = !stage_vld_q[6] || !cal_stall;
		load.s5 = !stage_vld_q[5] || load.s6;
		load.s4 = !stage_vld_q[4] || load.s5;
		load.s3 = !stage_vld_q[3] || load.s4;
		load.s2 = !stage_vld_q[2] || load.s3;
		load.s1 = !stage_vld_q[1] || load.s2;
	end

	// Hold the input off only when the first stage holds a word that cannot move.
	assign epoch_stall = !load.s1;

	// Advance the valid bits along with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (load.s1)
				stage_vld_q[1] <= epoch_valid;
			if (load.s2)
				stage_vld_q[2] <= stage_vld_q[1];
			if (load.s3)
				stage_vld_q[3] <= stage_vld_q[2];
			if (load.s4)
				stage_vld_q[4] <= stage_vld_q[3];
			if (load.s5)
				stage_vld_q[5] <= stage_vld_q[4];
			if (load.s6)
				stage_vld_q[6] <= stage_vld_q[5];
		end
	end

	// Stages 1-2: split seconds into whole days and time of day.
	esc_split u_split (
		.clk           (clk),
		.load          (load),
		.epoch_seconds (epoch_seconds),
		.days_s2       (days_s2),
		.tod_s2        (tod_s2)
	);

	// Stages 3-6: days to year, month, day and weekday.
	esc_date u_date (
		.clk      (clk),
		.load     (load),
		.days_s2  (days_s2),
		.year_s6  (year_number),
		.month_s6 (month_index),
		.mday_s6  (day_of_month),
		.wday_s6  (weekday)
	);

	// Stages 3-6: time of day to hour, minute and second.
	esc_clock u_clock (
		.clk     (clk),
		.load    (load),
		.tod_s2  (tod_s2),
		.hour_s6 (hour_of_day),
		.min_s6  (minute_of_hour),
		.sec_s6  (second_of_minute)
	);

	// The last stage doubles as the output register.
	assign cal_valid = stage_vld_q[6];

	`ESC_ASSERT_IMP(a_date_range, cal_valid, (month_index <= LAST_MONTH) && (day_of_month != 5'd0))
	`ESC_ASSERT_IMP(a_wday_range, cal_valid, weekday < 3'd7)
	`ESC_ASSERT_IMP(a_hour_range, cal_valid, hour_of_day < 5'd24)
	`ESC_ASSERT_IMP(a_ms_range, cal_valid, (minute_of_hour < 6'd60) && (second_of_minute < 6'd60))
	`ESC_ASSERT_IMP(a_out_from_s5, $rose(stage_vld_q[6]), $past(stage_vld_q[5]))
	`ESC_ASSERT_NXT(a_mid_hold, stage_vld_q[3] && !load.s3, stage_vld_q[3])

endmodule
